@@ rtl/core/gbn_sw_pkg.sv @@
// Shared types, widths and constants of the Go-Back-N sender window.
package gbn_sw_pkg;

   localparam int CMD_W      = 2;
   localparam int LEN_W      = 27;
   localparam int FNUM_W     = 8;
   localparam int SEQ_W      = 8;
   localparam int INDEX_BITS = 15;
   localparam int PLEN_W     = 13;
   localparam int KIND_W     = 2;
   localparam int TICK_W     = 32;
   localparam int WIN_W      = 4;
   localparam int TMO_W      = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam int PAYLOAD_BYTES  = 8000;
   localparam int DEF_MAX_WINDOW = 8;

   // floor(len / PAYLOAD_BYTES) by reciprocal; the estimate is low by at most one
   localparam int DIV_SHIFT = LEN_W + $clog2(PAYLOAD_BYTES);
   localparam longint unsigned DIV_RECIP = (64'd1 << DIV_SHIFT) / PAYLOAD_BYTES;
   localparam int RECIP_W = $clog2(DIV_RECIP + 1);
   localparam int PROD_W  = LEN_W + RECIP_W;
   localparam int Q_W     = PROD_W - DIV_SHIFT;
   localparam int QP_W    = Q_W + $clog2(PAYLOAD_BYTES + 1);
   localparam int CNT_W   = (Q_W + 1 > INDEX_BITS) ? Q_W + 1 : INDEX_BITS;

   localparam logic [INDEX_BITS-1:0] IDX_MAX   = '1;
   localparam logic [PLEN_W-1:0]     PLEN_FULL = PLEN_W'(PAYLOAD_BYTES);
   localparam logic [SEQ_W:0]        SEQ_SPACE = (SEQ_W+1)'(1 << SEQ_W);

   localparam logic [WIN_W-1:0] WIN_RESET = 4'd5;
   localparam logic [TMO_W-1:0] TMO_RESET = 16'd100;

   localparam logic [FNUM_W-1:0] CHAR_ONE   = 8'h31;
   localparam logic [FNUM_W-1:0] CHAR_TWO   = 8'h32;
   localparam logic [FNUM_W-1:0] CHAR_THREE = 8'h33;

   localparam logic [KIND_W-1:0] KIND_JPG = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TXT = 2'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_START = 2'd0,
      CMD_POLL  = 2'd1,
      CMD_ACK   = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW  = 1'b0,
      CSR_TIMEOUT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [LEN_W-1:0]  data_length;
      logic [FNUM_W-1:0] file_number;
      logic [SEQ_W-1:0]  ack_sequence;
      logic              ack_good;
   } req_data_type;

   typedef struct packed {
      req_data_type   req;
      logic [Q_W-1:0] q_est;
   } s1_type;

   typedef struct packed {
      req_data_type     req;
      logic [Q_W-1:0]   q_est;
      logic [LEN_W-1:0] rem_raw;
   } prep_type;

   typedef struct packed {
      logic                  send_valid;
      logic [INDEX_BITS-1:0] packet_index;
      logic [SEQ_W-1:0]      sequence_number;
      logic [LEN_W-1:0]      byte_offset;
      logic [PLEN_W-1:0]     payload_length;
      logic [KIND_W-1:0]     file_kind;
      logic [INDEX_BITS-1:0] window_head;
      logic [INDEX_BITS-1:0] next_to_send;
      logic                  timed_out;
      logic                  transfer_done;
   } rsp_data_type;

   typedef struct packed {
      logic              clear;
      logic              push;
      logic              pop;
      logic [SEQ_W:0]    pop_num;
      logic [TICK_W-1:0] push_time;
   } fifo_ctl_type;

endpackage

@@ rtl/core/gbn_sw_req_if.sv @@
// Request channel: command and operands for the sender window.
interface gbn_sw_req_if;
   import gbn_sw_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [LEN_W-1:0]  data_length;
   logic [FNUM_W-1:0] file_number;
   logic [SEQ_W-1:0]  ack_sequence;
   logic              ack_good;

   modport source (
      output valid, command, data_length, file_number, ack_sequence, ack_good,
      input  ready
   );

   modport sink (
      input  valid, command, data_length, file_number, ack_sequence, ack_good,
      output ready
   );
endinterface

@@ rtl/core/gbn_sw_rsp_if.sv @@
// Response channel: send decision and window status.
interface gbn_sw_rsp_if;
   import gbn_sw_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  send_valid;
   logic [INDEX_BITS-1:0] packet_index;
   logic [SEQ_W-1:0]      sequence_number;
   logic [LEN_W-1:0]      byte_offset;
   logic [PLEN_W-1:0]     payload_length;
   logic [KIND_W-1:0]     file_kind;
   logic [INDEX_BITS-1:0] window_head;
   logic [INDEX_BITS-1:0] next_to_send;
   logic                  timed_out;
   logic                  transfer_done;

   modport source (
      output valid, send_valid, packet_index, sequence_number, byte_offset,
             payload_length, file_kind, window_head, next_to_send, timed_out,
             transfer_done,
      input  ready
   );

   modport sink (
      input  valid, send_valid, packet_index, sequence_number, byte_offset,
             payload_length, file_kind, window_head, next_to_send, timed_out,
             transfer_done,
      output ready
   );
endinterface

@@ rtl/core/gbn_sw_prep.sv @@
// Two-stage input pipe: reciprocal divide of the length, then the remainder.
module gbn_sw_prep (
   input  logic                 clock,
   input  logic                 reset,
   gbn_sw_req_if.sink           req_bus,
   input  logic                 take,
   output logic                 s2_valid,
   output gbn_sw_pkg::prep_type s2_data
);
   import gbn_sw_pkg::*;

   logic              s1_v_ff, s1_v_in;
   s1_type            s1_ff, s1_in;
   logic              s2_v_ff, s2_v_in;
   prep_type          s2_ff, s2_in;
   logic              en1, en2;
   logic [PROD_W-1:0] prod;
   logic [QP_W-1:0]   qp;

   assign en2 = !s2_v_ff || take;
   assign en1 = !s1_v_ff || en2;
   assign req_bus.ready = en1;

   always_comb begin
      prod = PROD_W'(req_bus.data_length) * PROD_W'(DIV_RECIP);
      s1_in.req.command      = req_bus.command;
      s1_in.req.data_length  = req_bus.data_length;
      s1_in.req.file_number  = req_bus.file_number;
      s1_in.req.ack_sequence = req_bus.ack_sequence;
      s1_in.req.ack_good     = req_bus.ack_good;
      s1_in.q_est            = prod[PROD_W-1:DIV_SHIFT];
      s1_v_in                = req_bus.valid;
   end

   always_comb begin
      qp            = QP_W'(s1_ff.q_est) * QP_W'(PAYLOAD_BYTES);
      s2_in.req     = s1_ff.req;
      s2_in.q_est   = s1_ff.q_est;
      s2_in.rem_raw = s1_ff.req.data_length - LEN_W'(qp);
      s2_v_in       = s1_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         if (en1) begin
            s1_v_ff <= s1_v_in;
         end
         if (en2) begin
            s2_v_ff <= s2_v_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ff <= s1_in;
      end
      if (en2) begin
         s2_ff <= s2_in;
      end
   end

   assign s2_valid = s2_v_ff;
   assign s2_data  = s2_ff;

   assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && !en2 |=> s1_v_ff && $stable(s1_ff))
      else $error("stage one item lost while stage two stalled");
endmodule

@@ rtl/core/gbn_sw_fifo.sv @@
// Send-time queue of outstanding packets, circular over MAX_WINDOW entries.
module gbn_sw_fifo #(
   parameter int MAX_WINDOW = gbn_sw_pkg::DEF_MAX_WINDOW
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gbn_sw_pkg::fifo_ctl_type             ctl,
   output logic                                 empty,
   output logic [gbn_sw_pkg::TICK_W-1:0]        oldest
);
   import gbn_sw_pkg::*;

   localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int FC_W  = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W = FC_W + 1;

   logic [TICK_W-1:0] mem_ff [MAX_WINDOW];
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [FC_W-1:0]   count_ff, count_in;
   logic [SEQ_W:0]    pop9;
   logic [FC_W-1:0]   pop_amt;
   logic [SUM_W-1:0]  rd_sum, wr_sum;
   logic [PTR_W-1:0]  wr_ptr;
   logic              do_write;

   always_comb begin
      pop9    = ((SEQ_W+1)'(count_ff) < ctl.pop_num) ? (SEQ_W+1)'(count_ff) : ctl.pop_num;
      pop_amt = FC_W'(pop9);
      rd_sum  = SUM_W'(rd_ff) + SUM_W'(pop_amt);
      if (rd_sum >= SUM_W'(MAX_WINDOW)) begin
         rd_sum = rd_sum - SUM_W'(MAX_WINDOW);
      end
      wr_sum = SUM_W'(rd_ff) + SUM_W'(count_ff);
      if (wr_sum >= SUM_W'(MAX_WINDOW)) begin
         wr_sum = wr_sum - SUM_W'(MAX_WINDOW);
      end
      wr_ptr   = PTR_W'(wr_sum);
      do_write = 1'b0;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (ctl.clear) begin
         rd_in    = '0;
         count_in = '0;
      end else if (ctl.pop) begin
         rd_in    = PTR_W'(rd_sum);
         count_in = count_ff - pop_amt;
      end else if (ctl.push && count_ff < FC_W'(MAX_WINDOW)) begin
         do_write = 1'b1;
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem_ff[wr_ptr] <= ctl.push_time;
      end
   end

   assign empty  = (count_ff == '0);
   assign oldest = mem_ff[rd_ff];

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= FC_W'(MAX_WINDOW))
      else $error("send-time queue overfilled");

   assert property (@(posedge clock) disable iff (reset)
      ctl.clear |=> count_ff == '0)
      else $error("send-time queue not emptied by clear");
endmodule

@@ rtl/core/go_back_n_sender_window_top.sv @@
// Go-Back-N sender window controller, top level.
//
// req_bus carries one command per request: start a transfer (length and file
// number), poll (one tick, maybe send the next packet, check the timeout) or
// ack (cumulative sequence number and checksum flag). Every request yields
// exactly one response on rsp_bus with the send decision and window status.
// Both channels use valid/ready; a request is taken when both are high.
// csr_write_enable/csr_index/csr_write_data set the window size and the
// timeout; write them only while no request is in flight.
//
// From request to response there is a reciprocal-multiply stage, a
// remainder stage, then the window update into the response register.
// Throughput is one request per cycle while rsp_bus is ready.
// A stalled rsp_bus holds the response and backs up the pipe; the input stages
// keep filling until all three hold a request. Reset empties the pipe and sets
// window 5, timeout 100, file kind TXT; the send-time queue holds MAX_WINDOW
// entries in flip-flops and needs no clearing pass.
module go_back_n_sender_window_top #(
   parameter int MAX_WINDOW = gbn_sw_pkg::DEF_MAX_WINDOW
) (
   input  logic                              clock,
   input  logic                              reset,
   gbn_sw_req_if.sink                        req_bus,
   gbn_sw_rsp_if.source                      rsp_bus,
   input  logic                              csr_write_enable,
   input  logic [gbn_sw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gbn_sw_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import gbn_sw_pkg::*;

   localparam int WCMP_W = ($clog2(MAX_WINDOW + 1) > WIN_W) ? $clog2(MAX_WINDOW + 1) : WIN_W;

   logic                  s2_v;
   prep_type              s2;
   logic                  take, fire;
   fifo_ctl_type          fctl;
   logic                  f_empty;
   logic [TICK_W-1:0]     f_oldest;

   logic [INDEX_BITS-1:0] total_ff, total_in;
   logic [PLEN_W-1:0]     last_len_ff, last_len_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [INDEX_BITS-1:0] head_ff, head_in;
   logic [INDEX_BITS-1:0] next_ff, next_in;
   logic [TICK_W-1:0]     tick_ff, tick_in;
   logic [WIN_W-1:0]      window_ff;
   logic [TMO_W-1:0]      timeout_ff;
   logic                  out_v_ff;
   rsp_data_type          out_ff, out_in;

   cmd_type               cmd;
   logic [WCMP_W-1:0]     win_wide, win_eff;
   logic                  fix;
   logic [Q_W-1:0]        q_fix;
   logic [LEN_W-1:0]      rem_fix;
   logic [PLEN_W-1:0]     rem_n;
   logic [CNT_W-1:0]      cnt;
   logic [INDEX_BITS:0]   diff;
   logic                  send, tout;
   logic [PLEN_W-1:0]     plen;
   logic [TICK_W-1:0]     tick_new, old_t;
   logic                  has_entry;
   logic [SEQ_W:0]        h9, a9, w9, num;
   logic [INDEX_BITS:0]   nh;

   gbn_sw_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .take     (take),
      .s2_valid (s2_v),
      .s2_data  (s2)
   );

   gbn_sw_fifo #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_fifo (
      .clock  (clock),
      .reset  (reset),
      .ctl    (fctl),
      .empty  (f_empty),
      .oldest (f_oldest)
   );

   assign take = !out_v_ff || rsp_bus.ready;
   assign fire = s2_v && take;
   assign cmd  = cmd_type'(s2.req.command);

   always_comb begin
      win_wide = WCMP_W'(window_ff);
      if (win_wide == '0) begin
         win_eff = WCMP_W'(1);
      end else if (win_wide > WCMP_W'(MAX_WINDOW)) begin
         win_eff = WCMP_W'(MAX_WINDOW);
      end else begin
         win_eff = win_wide;
      end
   end

   always_comb begin
      fix     = (s2.rem_raw >= LEN_W'(PAYLOAD_BYTES));
      q_fix   = s2.q_est + Q_W'(fix);
      rem_fix = fix ? s2.rem_raw - LEN_W'(PAYLOAD_BYTES) : s2.rem_raw;
      rem_n   = PLEN_W'(rem_fix);
      cnt     = CNT_W'(q_fix) + CNT_W'(rem_n != '0);
   end

   always_comb begin
      total_in    = total_ff;
      last_len_in = last_len_ff;
      kind_in     = kind_ff;
      head_in     = head_ff;
      next_in     = next_ff;
      tick_in     = tick_ff;
      send        = 1'b0;
      tout        = 1'b0;
      plen        = '0;
      tick_new    = tick_ff + 1'b1;
      diff        = {1'b0, next_ff} - {1'b0, head_ff};
      old_t       = f_oldest;
      has_entry   = 1'b0;
      h9          = {1'b0, head_ff[SEQ_W-1:0]};
      a9          = {1'b0, s2.req.ack_sequence};
      w9          = (SEQ_W+1)'(win_eff);
      num         = '0;
      nh          = '0;
      fctl        = '0;
      fctl.push_time = tick_new;
      case (cmd)
         CMD_START: begin
            total_in    = (cnt > CNT_W'(IDX_MAX)) ? IDX_MAX : INDEX_BITS'(cnt);
            last_len_in = (rem_n == '0) ? PLEN_FULL : rem_n;
            kind_in     = (s2.req.file_number == CHAR_ONE || s2.req.file_number == CHAR_TWO ||
                           s2.req.file_number == CHAR_THREE) ? KIND_JPG : KIND_TXT;
            head_in     = '0;
            next_in     = '0;
            fctl.clear  = fire;
         end
         CMD_POLL: begin
            tick_in = tick_new;
            if (!diff[INDEX_BITS] && diff < (INDEX_BITS+1)'(win_eff) && next_ff < total_ff) begin
               send    = 1'b1;
               plen    = ({1'b0, next_ff} + 1'b1 == {1'b0, total_ff}) ? last_len_ff : PLEN_FULL;
               next_in = next_ff + 1'b1;
            end
            fctl.push = fire && send;
            has_entry = !f_empty || send;
            if (f_empty) begin
               old_t = tick_new;
            end
            if (has_entry && (tick_new - old_t) > TICK_W'(timeout_ff)) begin
               tout       = 1'b1;
               next_in    = head_ff;
               fctl.clear = fire;
            end
         end
         CMD_ACK: begin
            if (!s2.req.ack_good) begin
               next_in    = head_ff;
               fctl.clear = fire;
            end else begin
               if (a9 >= h9) begin
                  num = a9 - h9 + 1'b1;
               end else if (h9 > SEQ_SPACE - w9 && a9 + (SEQ_SPACE - h9) < w9) begin
                  num = SEQ_SPACE - h9 + a9 + 1'b1;
               end
               if (num != '0) begin
                  nh           = {1'b0, head_ff} + (INDEX_BITS+1)'(num);
                  head_in      = (nh > {1'b0, total_ff}) ? total_ff : INDEX_BITS'(nh);
                  fctl.pop     = fire;
                  fctl.pop_num = num;
                  if (next_ff < head_in) begin
                     next_in = head_in;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_in.send_valid      = send;
      out_in.packet_index    = send ? next_ff : '0;
      out_in.sequence_number = send ? next_ff[SEQ_W-1:0] : '0;
      out_in.byte_offset     = send ? LEN_W'(32'(next_ff) * 32'(PAYLOAD_BYTES)) : '0;
      out_in.payload_length  = plen;
      out_in.file_kind       = kind_in;
      out_in.window_head     = head_in;
      out_in.next_to_send    = next_in;
      out_in.timed_out       = tout;
      out_in.transfer_done   = (head_in >= total_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= '0;
         last_len_ff <= '0;
         kind_ff     <= KIND_TXT;
         head_ff     <= '0;
         next_ff     <= '0;
         tick_ff     <= '0;
         out_v_ff    <= 1'b0;
      end else begin
         if (fire) begin
            total_ff    <= total_in;
            last_len_ff <= last_len_in;
            kind_ff     <= kind_in;
            head_ff     <= head_in;
            next_ff     <= next_in;
            tick_ff     <= tick_in;
         end
         if (take) begin
            out_v_ff <= s2_v;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= WIN_RESET;
         timeout_ff <= TMO_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_WINDOW:  window_ff  <= WIN_W'(csr_write_data);
            CSR_TIMEOUT: timeout_ff <= TMO_W'(csr_write_data);
            default: begin
            end
         endcase
      end
   end

   assign rsp_bus.valid           = out_v_ff;
   assign rsp_bus.send_valid      = out_ff.send_valid;
   assign rsp_bus.packet_index    = out_ff.packet_index;
   assign rsp_bus.sequence_number = out_ff.sequence_number;
   assign rsp_bus.byte_offset     = out_ff.byte_offset;
   assign rsp_bus.payload_length  = out_ff.payload_length;
   assign rsp_bus.file_kind       = out_ff.file_kind;
   assign rsp_bus.window_head     = out_ff.window_head;
   assign rsp_bus.next_to_send    = out_ff.next_to_send;
   assign rsp_bus.timed_out       = out_ff.timed_out;
   assign rsp_bus.transfer_done   = out_ff.transfer_done;

   assert property (@(posedge clock) disable iff (reset)
      head_ff <= next_ff && head_ff <= total_ff)
      else $error("window head passed next index or packet total");

   assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_ff.send_valid |-> out_ff.packet_index < total_ff)
      else $error("sent packet outside the transfer");

   assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_ff.timed_out |-> out_ff.next_to_send == out_ff.window_head)
      else $error("timeout did not rewind to the window head");
endmodule

@@ dv/go_back_n_sender_window_top_test.sv @@
// Self-checking testbench for the Go-Back-N sender window: directed corners, then random transfers.
module go_back_n_sender_window_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import gbn_sw_pkg::*;

   localparam int WINDOW_CAP       = DEF_MAX_WINDOW;
   localparam int RANDOM_ITEMS     = 1350;
   localparam int PHASES           = 7;
   localparam int SETTLE_CYCLES    = 6;
   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int LONG_HOLD_AFTER  = 400;
   localparam int LONG_HOLD_CYCLES = 64;

   class gbn_window_scoreboard;
      logic [WIN_W-1:0]      window_reg;
      logic [TMO_W-1:0]      timeout_reg;
      logic [INDEX_BITS-1:0] total;
      logic [LEN_W-1:0]      len_total;
      logic [KIND_W-1:0]     kind;
      logic [INDEX_BITS-1:0] head;
      logic [INDEX_BITS-1:0] next_idx;
      logic [TICK_W-1:0]     ticks;
      logic [TICK_W-1:0]     sent_at [WINDOW_CAP];
      int unsigned           rd_ptr;
      int unsigned           fill;
      rsp_data_type          expected_q [$];
      int unsigned           fail_count;

      function new();
         window_reg  = WIN_RESET;
         timeout_reg = TMO_RESET;
         total       = '0;
         len_total   = '0;
         kind        = KIND_TXT;
         head        = '0;
         next_idx    = '0;
         ticks       = '0;
         foreach (sent_at[i]) sent_at[i] = '0;
         rd_ptr      = 0;
         fill        = 0;
         fail_count  = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_WINDOW:  window_reg  = data[WIN_W-1:0];
            CSR_TIMEOUT: timeout_reg = data[TMO_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned window_eff();
         if (window_reg == 0) return 1;
         if (window_reg > WINDOW_CAP) return WINDOW_CAP;
         return window_reg;
      endfunction

      function bit finished();
         return head >= total;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void clear_times();
         rd_ptr = 0;
         fill   = 0;
      endfunction

      function void note_request(req_data_type r);
         rsp_data_type e;
         int unsigned  len, cnt, rem, win, h8, aseq, num, nh;
         int unsigned  seq_span;
         e = '0;
         seq_span = 1 << SEQ_W;
         case (r.command)
            CMD_START: begin
               len = r.data_length;
               cnt = len / PAYLOAD_BYTES;
               if (len % PAYLOAD_BYTES != 0) cnt++;
               if (cnt > IDX_MAX) cnt = IDX_MAX;
               total     = INDEX_BITS'(cnt);
               len_total = r.data_length;
               kind = (r.file_number == CHAR_ONE || r.file_number == CHAR_TWO ||
                       r.file_number == CHAR_THREE) ? KIND_JPG : KIND_TXT;
               head     = '0;
               next_idx = '0;
               clear_times();
            end
            CMD_POLL: begin
               ticks = ticks + 1'b1;
               if (32'(next_idx) - 32'(head) < window_eff() && next_idx < total) begin
                  e.send_valid      = 1'b1;
                  e.packet_index    = next_idx;
                  e.sequence_number = next_idx[SEQ_W-1:0];
                  e.byte_offset     = LEN_W'(32'(next_idx) * PAYLOAD_BYTES);
                  if (32'(next_idx) + 1 == 32'(total)) begin
                     rem = len_total % PAYLOAD_BYTES;
                     e.payload_length = (rem == 0) ? PLEN_FULL : PLEN_W'(rem);
                  end else begin
                     e.payload_length = PLEN_FULL;
                  end
                  next_idx = next_idx + 1'b1;
                  if (fill < WINDOW_CAP) begin
                     sent_at[(rd_ptr + fill) % WINDOW_CAP] = ticks;
                     fill++;
                  end
               end
               if (fill != 0 && ticks - sent_at[rd_ptr] > 32'(timeout_reg)) begin
                  next_idx    = head;
                  clear_times();
                  e.timed_out = 1'b1;
               end
            end
            CMD_ACK: begin
               if (!r.ack_good) begin
                  next_idx = head;
                  clear_times();
               end else begin
                  win  = window_eff();
                  h8   = head % seq_span;
                  aseq = r.ack_sequence;
                  num  = 0;
                  if (aseq >= h8)
                     num = aseq - h8 + 1;
                  else if (h8 > seq_span - win && aseq + (seq_span - h8) < win)
                     num = seq_span - h8 + aseq + 1;
                  if (num != 0) begin
                     nh = head + num;
                     if (nh > total) nh = total;
                     head = INDEX_BITS'(nh);
                     while (fill != 0 && num != 0) begin
                        rd_ptr = (rd_ptr + 1) % WINDOW_CAP;
                        fill--;
                        num--;
                     end
                     if (next_idx < head) next_idx = head;
                  end
               end
            end
            default: ;
         endcase
         e.file_kind     = kind;
         e.window_head   = head;
         e.next_to_send  = next_idx;
         e.transfer_done = (head >= total);
         expected_q.push_back(e);
      endfunction

      function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
         if (exp !== act) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp, act);
            fail_count++;
         end
      endfunction

      function void check_response(rsp_data_type got);
         rsp_data_type e;
         if (expected_q.size() == 0) begin
            $error("response with no request outstanding");
            fail_count++;
            return;
         end
         e = expected_q.pop_front();
         compare_field("send_valid", e.send_valid, got.send_valid);
         compare_field("packet_index", e.packet_index, got.packet_index);
         compare_field("sequence_number", e.sequence_number, got.sequence_number);
         compare_field("byte_offset", e.byte_offset, got.byte_offset);
         compare_field("payload_length", e.payload_length, got.payload_length);
         compare_field("file_kind", e.file_kind, got.file_kind);
         compare_field("window_head", e.window_head, got.window_head);
         compare_field("next_to_send", e.next_to_send, got.next_to_send);
         compare_field("timed_out", e.timed_out, got.timed_out);
         compare_field("transfer_done", e.transfer_done, got.transfer_done);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   bit                    quiet = 1'b0;
   int unsigned           rsp_count = 0;
   int unsigned           stall_cycles = 0;

   gbn_window_scoreboard sb = new();

   gbn_sw_req_if req_bus ();
   gbn_sw_rsp_if rsp_bus ();

   go_back_n_sender_window_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic req_data_type req_item(cmd_type c, int unsigned len, int unsigned fnum,
                                             int unsigned seq, bit good);
      req_data_type r;
      r.command      = c;
      r.data_length  = LEN_W'(len);
      r.file_number  = FNUM_W'(fnum);
      r.ack_sequence = SEQ_W'(seq);
      r.ack_good     = good;
      return r;
   endfunction

   function automatic logic [LEN_W-1:0] pick_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 20)
         return LEN_W'($urandom_range(260, 600) * PAYLOAD_BYTES - $urandom_range(0, 7999));
      if (roll < 32)
         return LEN_W'($urandom_range(1, 12) * PAYLOAD_BYTES);
      if (roll < 38)
         return LEN_W'($urandom_range(0, PAYLOAD_BYTES - 1));
      return LEN_W'($urandom_range(1, 15) * PAYLOAD_BYTES - $urandom_range(1, 7999));
   endfunction

   function automatic logic [FNUM_W-1:0] pick_file();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return FNUM_W'(CHAR_ONE + $urandom_range(0, 2));
      if (roll < 65) return CHAR_ONE - 1'b1;
      if (roll < 75) return CHAR_THREE + 1'b1;
      return FNUM_W'($urandom);
   endfunction

   // next step within a transfer, steered by the predicted window; now and then a NOP or a fresh start
   function automatic req_data_type pick_event();
      req_data_type r;
      int unsigned  roll, span;
      r.data_length  = LEN_W'($urandom);
      r.file_number  = FNUM_W'($urandom);
      r.ack_sequence = SEQ_W'($urandom);
      r.ack_good     = 1'($urandom);
      roll = $urandom_range(0, 99);
      span = sb.next_idx - sb.head;
      if (roll < 46) begin
         r.command = CMD_POLL;
      end else if (roll < 80) begin
         r.command      = CMD_ACK;
         r.ack_good     = 1'b1;
         r.ack_sequence = SEQ_W'(sb.head + $urandom_range(0, span));
      end else if (roll < 86) begin
         r.command  = CMD_ACK;
         r.ack_good = 1'b1;
      end else if (roll < 90) begin
         r.command      = CMD_ACK;
         r.ack_good     = 1'b1;
         r.ack_sequence = SEQ_W'(sb.head - 1 - $urandom_range(0, 3));
      end else if (roll < 95) begin
         r.command  = CMD_ACK;
         r.ack_good = 1'b0;
      end else if (roll < 98) begin
         r.command = CMD_NOP;
      end else begin
         r.command = CMD_START;
      end
      return r;
   endfunction

   task automatic send_req(req_data_type r);
      req_bus.valid        <= 1'b1;
      req_bus.command      <= r.command;
      req_bus.data_length  <= r.data_length;
      req_bus.file_number  <= r.file_number;
      req_bus.ack_sequence <= r.ack_sequence;
      req_bus.ack_good     <= r.ack_good;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(r);
      if (!quiet && $urandom_range(0, 99) < 15) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(logic [WIN_W-1:0] win, logic [TMO_W-1:0] tmo);
      logic [CSR_DATA_W-1:0] data;
      data = {(CSR_DATA_W - WIN_W)'($urandom), win};
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_WINDOW;
      csr_write_data   <= data;
      @(posedge clock);
      sb.write_reg(CSR_WINDOW, data);
      csr_index        <= CSR_TIMEOUT;
      csr_write_data   <= CSR_DATA_W'(tmo);
      @(posedge clock);
      sb.write_reg(CSR_TIMEOUT, CSR_DATA_W'(tmo));
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_phase(int unsigned quota);
      req_data_type r;
      int unsigned  issued, tail;
      issued = 0;
      while (issued < quota) begin
         r = req_item(CMD_START, 0, 0, $urandom, 1'($urandom));
         r.data_length = pick_length();
         r.file_number = pick_file();
         send_req(r);
         issued++;
         tail = $urandom_range(0, 3);
         while (issued < quota && (!sb.finished() || tail != 0)) begin
            if (sb.finished()) tail--;
            r = pick_event();
            send_req(r);
            if (r.command != CMD_NOP) issued++;
         end
      end
   endtask

   always @(posedge clock) begin : response_monitor
      rsp_data_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.send_valid      = rsp_bus.send_valid;
         got.packet_index    = rsp_bus.packet_index;
         got.sequence_number = rsp_bus.sequence_number;
         got.byte_offset     = rsp_bus.byte_offset;
         got.payload_length  = rsp_bus.payload_length;
         got.file_kind       = rsp_bus.file_kind;
         got.window_head     = rsp_bus.window_head;
         got.next_to_send    = rsp_bus.next_to_send;
         got.timed_out       = rsp_bus.timed_out;
         got.transfer_done   = rsp_bus.transfer_done;
         sb.check_response(got);
         rsp_count <= rsp_count + 1;
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : response_side
      bit held_long;
      held_long = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_long && rsp_count >= LONG_HOLD_AFTER) begin
            held_long = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 99) < 25) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      req_data_type     basic_q [$];
      req_data_type     timeout_q [$];
      logic [WIN_W-1:0] win_set [PHASES];
      logic [TMO_W-1:0] tmo_set [PHASES];

      win_set = '{4'd8, 4'd15, 4'd1, 4'd3, 4'd0, 4'd7, 4'd5};
      tmo_set = '{16'd3, 16'd20, 16'd65535, 16'd6, 16'd1, 16'd12, 16'd100};

      req_bus.valid        <= 1'b0;
      req_bus.command      <= CMD_NOP;
      req_bus.data_length  <= '0;
      req_bus.file_number  <= '0;
      req_bus.ack_sequence <= '0;
      req_bus.ack_good     <= 1'b0;
      csr_write_enable     <= 1'b0;
      csr_index            <= CSR_WINDOW;
      csr_write_data       <= '0;

      basic_q = '{
         req_item(CMD_NOP, (1 << LEN_W) - 1, 8'hFF, 8'hFF, 1'b1),
         req_item(CMD_POLL, 0, 0, 0, 1'b0),
         req_item(CMD_ACK, 0, 0, 0, 1'b1),
         req_item(CMD_START, 0, CHAR_ONE, 0, 1'b0),
         req_item(CMD_POLL, 0, 0, 0, 1'b0),
         req_item(CMD_START, (1 << LEN_W) - 1, CHAR_THREE, 8'hFF, 1'b1),
         req_item(CMD_POLL, 0, 0, 0, 1'b0),
         req_item(CMD_POLL, 0, 0, 0, 1'b0),
         req_item(CMD_ACK, 0, 0, 0, 1'b0),
         req_item(CMD_POLL, 0, 0, 0, 1'b0),
         req_item(CMD_ACK, 0, 0, 0, 1'b1),
         req_item(CMD_ACK, 0, 0, 200, 1'b1),
         req_item(CMD_ACK, 0, 0, 3, 1'b1),
         req_item(CMD_START, PAYLOAD_BYTES, CHAR_THREE + 1, 0, 1'b0),
         req_item(CMD_POLL, 0, 0, 0, 1'b0),
         req_item(CMD_POLL, 0, 0, 0, 1'b0),
         req_item(CMD_ACK, 0, 0, 0, 1'b1),
         req_item(CMD_START, PAYLOAD_BYTES + 1, 8'hFF, 0, 1'b0),
         req_item(CMD_POLL, 0, 0, 0, 1'b0),
         req_item(CMD_POLL, 0, 0, 0, 1'b0),
         req_item(CMD_ACK, 0, 0, 7, 1'b1),
         req_item(CMD_START, 1, CHAR_TWO, 0, 1'b0),
         req_item(CMD_POLL, 0, 0, 0, 1'b0)
      };
      timeout_q = '{
         req_item(CMD_START, 5 * PAYLOAD_BYTES, 8'h00, 0, 1'b0),
         req_item(CMD_POLL, 0, 0, 0, 1'b0),
         req_item(CMD_POLL, 0, 0, 0, 1'b0),
         req_item(CMD_POLL, 0, 0, 0, 1'b0)
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (basic_q[i]) send_req(basic_q[i]);
      drain();
      // window 0 behaves as 1; timeout of 1
      program_regs(4'd0, 16'd1);
      foreach (timeout_q[i]) send_req(timeout_q[i]);

      for (int p = 0; p < PHASES; p++) begin
         drain();
         if (p == PHASES - 1) quiet = 1'b1;
         program_regs(win_set[p], tmo_set[p]);
         run_phase(RANDOM_ITEMS / PHASES);
      end

      drain();
      if (sb.fail_count == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/core/gbn_sw_pkg.sv
rtl/core/gbn_sw_req_if.sv
rtl/core/gbn_sw_rsp_if.sv
rtl/core/gbn_sw_prep.sv
rtl/core/gbn_sw_fifo.sv
rtl/core/go_back_n_sender_window_top.sv
dv/go_back_n_sender_window_top_test.sv
